@@ src/mcpfm_pkg.sv @@
// Package for the multi-channel pipe manager: sizes, codes, payload types.
// No dependencies.
`default_nettype none
package mcpfm_pkg;
   localparam int PipeCount = 8;
   localparam int PipeDepth = 1024;
   localparam int SlotW = (PipeCount > 1) ? $clog2(PipeCount) : 1;
   localparam int PtrW = $clog2(PipeDepth);
   localparam int FillW = $clog2(PipeDepth + 1);
   localparam int AddrW = SlotW + PtrW;

   typedef enum logic [2:0] {
      CMD_CREATE = 3'd0,
      CMD_WRITE  = 3'd1,
      CMD_READ   = 3'd2,
      CMD_CLOSE  = 3'd3,
      CMD_QUERY  = 3'd4
   } cmd_type;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_BADFD = 3'd1;
   localparam logic [2:0] ST_BROKEN = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_EOF = 3'd4;
   localparam logic [2:0] ST_NOFREE = 3'd5;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] descriptor;
      logic [7:0]  write_byte;
      logic [7:0]  requester_pid;
      logic        last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  read_byte;
      logic [15:0] new_read_descriptor;
      logic [15:0] new_write_descriptor;
      logic        wake_valid;
      logic [7:0]  wake_pid;
      logic        is_pipe;
      logic        last_of_call;
   } rsp_type;

   // Classified command handed from the front to the back.
   typedef struct packed {
      req_type          req;
      logic             hit;
      logic [SlotW-1:0] slot;
      logic             is_read_end;
      logic             is_write_end;
      logic             free_found;
      logic [SlotW-1:0] free_slot;
      logic             above_base;
   } job_type;
endpackage
`default_nettype wire

@@ src/multi_channel_pipe_fifo_manager.sv @@
// Pipe manager: the response is registered; a byte read waits for the memory read.
// One command in flight; the next request is taken the cycle after the response transfer.
// Commands are spaced by the slot table update and the registered memory read,
// plus any wait of the response for the receiver.
// Synchronous reset clears all slots; the descriptor base returns to 3.
// Depends on mcpfm_pkg, mcpfm_front and mcpfm_back.
`default_nettype none
module multi_channel_pipe_fifo_manager import mcpfm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);
   logic job_valid, job_ready, busy;
   job_type job;
   logic [PipeCount-1:0] active;
   logic [PipeCount-1:0][15:0] rd_num, wr_num;
   logic [15:0] base;

   mcpfm_front u_front (.clock, .reset, .req_valid, .req_ready, .req_data, .active,
      .rd_num, .wr_num, .base, .back_busy(busy), .job_valid, .job_ready, .job);
   mcpfm_back u_back (.clock, .reset, .csr_valid, .csr_ready, .csr_data, .job_valid,
      .job_ready, .job, .active, .rd_num, .wr_num, .base, .busy, .rsp_valid, .rsp_ready,
      .rsp_data);
endmodule
`default_nettype wire

@@ src/mcpfm_front.sv @@
// Front part: accepts requests, matches descriptors against active slots.
// Depends on mcpfm_pkg; slot table state comes from the back part.
`default_nettype none
module mcpfm_front import mcpfm_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   input  wire logic [PipeCount-1:0]   active,
   input  wire logic [PipeCount-1:0][15:0] rd_num,
   input  wire logic [PipeCount-1:0][15:0] wr_num,
   input  wire logic [15:0]            base,
   input  wire logic                   back_busy,
   output logic                        job_valid,
   input  wire logic                   job_ready,
   output job_type                     job
);
   logic    full_ff, full_in;
   job_type job_ff, job_in;

   // One item in flight at a time: the back part owns all slot state.
   assign req_ready = !full_ff && !back_busy;
   assign job_valid = full_ff;
   assign job = job_ff;

   // Priority match on the lowest active slot, and lowest free slot.
   always_comb begin
      job_in = job_ff;
      full_in = full_ff;
      if (job_ready && full_ff) full_in = 1'b0;
      if (req_valid && req_ready) begin
         full_in = 1'b1;
         job_in.req = req_data;
         job_in.hit = 1'b0;
         job_in.slot = '0;
         job_in.is_read_end = 1'b0;
         job_in.is_write_end = 1'b0;
         job_in.free_found = 1'b0;
         job_in.free_slot = '0;
         job_in.above_base = req_data.descriptor >= base;
         for (int i = PipeCount - 1; i >= 0; i--) begin
            if (active[i] && (rd_num[i] == req_data.descriptor ||
                              wr_num[i] == req_data.descriptor)) begin
               job_in.hit = 1'b1;
               job_in.slot = SlotW'(i);
               job_in.is_read_end = rd_num[i] == req_data.descriptor;
               job_in.is_write_end = wr_num[i] == req_data.descriptor;
            end
            if (!active[i]) begin
               job_in.free_found = 1'b1;
               job_in.free_slot = SlotW'(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else full_ff <= full_in;
      job_ff <= job_in;
   end
endmodule
`default_nettype wire

@@ src/mcpfm_back.sv @@
// Back part: executes classified commands on slot state and the byte memory.
// Depends on mcpfm_pkg.
`default_nettype none
module mcpfm_back import mcpfm_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [15:0]            csr_data,
   input  wire logic                   job_valid,
   output logic                        job_ready,
   input  wire job_type                job,
   output logic [PipeCount-1:0]        active,
   output logic [PipeCount-1:0][15:0]  rd_num,
   output logic [PipeCount-1:0][15:0]  wr_num,
   output logic [15:0]                 base,
   output logic                        busy,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data
);
   logic [PipeCount-1:0] act_ff, ropen_ff, wopen_ff, wrv_ff, wwv_ff;
   logic [PipeCount-1:0][15:0] rnum_ff, wnum_ff;
   logic [PipeCount-1:0][7:0] wrpid_ff, wwpid_ff;
   logic [PipeCount-1:0][PtrW-1:0] head_ff, tail_ff;
   logic [PipeCount-1:0][FillW-1:0] fill_ff;
   logic [15:0] base_ff, next_ff;
   logic [7:0] mem [PipeCount*PipeDepth];
   logic [7:0] mem_q;
   logic [AddrW-1:0] raddr;
   logic pend_ff, rdwait_ff, ovalid_ff;
   rsp_type out_ff, res;
   logic [SlotW-1:0] s;
   logic do_wr, do_rd;

   assign active = act_ff;
   assign rd_num = rnum_ff;
   assign wr_num = wnum_ff;
   assign base = base_ff;
   assign csr_ready = 1'b1;
   assign s = job.slot;
   // Byte reads wait on the read-wait flag for the registered memory output.
   assign job_ready = job_valid && !ovalid_ff && (rdwait_ff || !do_rd);
   assign busy = pend_ff || job_valid || ovalid_ff;
   assign rsp_valid = ovalid_ff;
   assign rsp_data = out_ff;
   assign raddr = {s, head_ff[s]};
   assign do_wr = job.req.cmd == CMD_WRITE && job.hit && job.is_write_end && !job.is_read_end
                  && ropen_ff[s] && fill_ff[s] < FillW'(PipeDepth);
   assign do_rd = job.req.cmd == CMD_READ && job.hit && job.is_read_end
                  && fill_ff[s] != '0;

   // Result fields for the command held by the front part.
   always_comb begin
      res = '0;
      res.last_of_call = job.req.last_byte;
      unique case (job.req.cmd)
         CMD_CREATE: begin
            if (!job.free_found) res.status = ST_NOFREE;
            else begin
               res.new_read_descriptor = next_ff;
               res.new_write_descriptor = next_ff + 16'd1;
            end
         end
         CMD_WRITE: begin
            if (!job.hit || !job.is_write_end || job.is_read_end) res.status = ST_BADFD;
            else if (!ropen_ff[s]) res.status = ST_BROKEN;
            else if (!do_wr) res.status = ST_WAIT;
            else begin
               res.wake_valid = wrv_ff[s];
               res.wake_pid = wrv_ff[s] ? wrpid_ff[s] : 8'd0;
            end
         end
         CMD_READ: begin
            if (!job.hit || !job.is_read_end) res.status = ST_BADFD;
            else if (do_rd) begin
               res.read_byte = mem_q;
               res.wake_valid = wwv_ff[s];
               res.wake_pid = wwv_ff[s] ? wwpid_ff[s] : 8'd0;
            end else if (!wopen_ff[s]) res.status = ST_EOF;
            else res.status = ST_WAIT;
         end
         CMD_CLOSE: begin
            if (!job.hit) res.status = ST_BADFD;
            else if (job.is_read_end) begin
               res.wake_valid = wwv_ff[s];
               res.wake_pid = wwv_ff[s] ? wwpid_ff[s] : 8'd0;
            end else begin
               res.wake_valid = wrv_ff[s];
               res.wake_pid = wrv_ff[s] ? wrpid_ff[s] : 8'd0;
            end
         end
         CMD_QUERY: res.is_pipe = job.above_base && job.hit;
         default: res.status = ST_BADFD;
      endcase
   end

   // Memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (job_ready && do_wr) mem[{s, tail_ff[s]}] <= job.req.write_byte;
      mem_q <= mem[raddr];
   end

   // Slot state update when a command completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0; ropen_ff <= '0; wopen_ff <= '0; wrv_ff <= '0; wwv_ff <= '0;
         head_ff <= '0; tail_ff <= '0; fill_ff <= '0;
         base_ff <= 16'd3; next_ff <= 16'd3;
         pend_ff <= 1'b0; rdwait_ff <= 1'b0; ovalid_ff <= 1'b0;
      end else begin
         pend_ff <= job_valid;
         if (rsp_valid && rsp_ready) ovalid_ff <= 1'b0;
         // The wait flag drops by itself in the cycle the read completes.
         rdwait_ff <= job_valid && do_rd && !rdwait_ff && !ovalid_ff;
         if (csr_valid) begin
            base_ff <= csr_data;
            next_ff <= csr_data;
         end
         if (job_ready) begin
            ovalid_ff <= 1'b1;
            out_ff <= res;
            unique case (job.req.cmd)
               CMD_CREATE: if (job.free_found) begin
                  act_ff[job.free_slot] <= 1'b1;
                  rnum_ff[job.free_slot] <= next_ff;
                  wnum_ff[job.free_slot] <= next_ff + 16'd1;
                  next_ff <= next_ff + 16'd2;
                  ropen_ff[job.free_slot] <= 1'b1;
                  wopen_ff[job.free_slot] <= 1'b1;
                  wrv_ff[job.free_slot] <= 1'b0;
                  wwv_ff[job.free_slot] <= 1'b0;
                  head_ff[job.free_slot] <= '0;
                  tail_ff[job.free_slot] <= '0;
                  fill_ff[job.free_slot] <= '0;
               end
               CMD_WRITE: if (res.status == ST_OK) begin
                  tail_ff[s] <= (tail_ff[s] == PtrW'(PipeDepth - 1)) ? '0
                                : tail_ff[s] + PtrW'(1);
                  fill_ff[s] <= fill_ff[s] + FillW'(1);
                  wrv_ff[s] <= 1'b0;
               end else if (res.status == ST_WAIT) begin
                  wwv_ff[s] <= 1'b1;
                  wwpid_ff[s] <= job.req.requester_pid;
               end
               CMD_READ: if (do_rd) begin
                  head_ff[s] <= (head_ff[s] == PtrW'(PipeDepth - 1)) ? '0
                                : head_ff[s] + PtrW'(1);
                  fill_ff[s] <= fill_ff[s] - FillW'(1);
                  wwv_ff[s] <= 1'b0;
               end else if (res.status == ST_WAIT) begin
                  wrv_ff[s] <= 1'b1;
                  wrpid_ff[s] <= job.req.requester_pid;
               end
               CMD_CLOSE: if (job.hit) begin
                  if (job.is_read_end) begin
                     ropen_ff[s] <= 1'b0;
                     wwv_ff[s] <= 1'b0;
                     if (!wopen_ff[s]) act_ff[s] <= 1'b0;
                  end else begin
                     wopen_ff[s] <= 1'b0;
                     wrv_ff[s] <= 1'b0;
                     if (!ropen_ff[s]) act_ff[s] <= 1'b0;
                  end
               end
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

@@ tb/multi_channel_pipe_fifo_manager_test.sv @@
// Self-checking testbench for the multi-channel pipe manager: random and directed
// pipe commands against a built-in predictor of the slot table and ring buffers.
// Depends on mcpfm_pkg and multi_channel_pipe_fifo_manager.
`default_nettype none
module multi_channel_pipe_fifo_manager_test;
   import mcpfm_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_data = '0;

   multi_channel_pipe_fifo_manager uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Clock with a period of two time units.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the pipe pool.
   logic [15:0] base_number;
   logic [15:0] counter_number;
   logic        pipe_active [PipeCount];
   logic [15:0] read_number [PipeCount];
   logic [15:0] write_number [PipeCount];
   logic        rd_open [PipeCount];
   logic        wr_open [PipeCount];
   logic        rd_wait [PipeCount];
   logic [7:0]  rd_wait_pid [PipeCount];
   logic        wr_wait [PipeCount];
   logic [7:0]  wr_wait_pid [PipeCount];
   int          head_idx [PipeCount];
   int          tail_idx [PipeCount];
   int          fill_count [PipeCount];
   logic [7:0]  pipe_bytes [PipeCount*PipeDepth];

   req_type pending_requests[$];
   rsp_type expected_responses[$];
   int      error_count = 0;

   // Idle percentages for sender and receiver, and the long receiver hold-off.
   int send_idle_pct = 23;
   int recv_idle_pct = 61;
   int hold_cycles = 0;

   function automatic int find_slot(logic [15:0] d);
      for (int i = 0; i < PipeCount; i++)
         if (pipe_active[i] && (read_number[i] == d || write_number[i] == d)) return i;
      return -1;
   endfunction

   function automatic void clear_pool();
      for (int i = 0; i < PipeCount; i++) begin
         pipe_active[i] = 0; rd_open[i] = 0; wr_open[i] = 0;
         rd_wait[i] = 0; wr_wait[i] = 0; head_idx[i] = 0; tail_idx[i] = 0;
         fill_count[i] = 0; read_number[i] = 0; write_number[i] = 0;
      end
      base_number = 16'd3;
      counter_number = 16'd3;
   endfunction

   // Computes the response of one accepted command and updates the shadow pool.
   function automatic rsp_type predict_response(req_type r);
      rsp_type o;
      int s;
      o = '0;
      o.status = ST_OK;
      o.last_of_call = r.last_byte;
      case (r.cmd)
         CMD_CREATE: begin
            s = -1;
            for (int i = 0; i < PipeCount; i++)
               if (s < 0 && !pipe_active[i]) s = i;
            if (s < 0) o.status = ST_NOFREE;
            else begin
               pipe_active[s] = 1;
               read_number[s] = counter_number;
               write_number[s] = counter_number + 16'd1;
               counter_number = counter_number + 16'd2;
               rd_open[s] = 1; wr_open[s] = 1; rd_wait[s] = 0; wr_wait[s] = 0;
               head_idx[s] = 0; tail_idx[s] = 0; fill_count[s] = 0;
               o.new_read_descriptor = read_number[s];
               o.new_write_descriptor = write_number[s];
            end
         end
         CMD_WRITE: begin
            s = find_slot(r.descriptor);
            if (s < 0 || write_number[s] != r.descriptor) o.status = ST_BADFD;
            else if (!rd_open[s]) o.status = ST_BROKEN;
            else if (fill_count[s] < PipeDepth) begin
               pipe_bytes[s*PipeDepth + tail_idx[s]] = r.write_byte;
               tail_idx[s] = (tail_idx[s] + 1) % PipeDepth;
               fill_count[s]++;
               if (rd_wait[s]) begin
                  o.wake_valid = 1; o.wake_pid = rd_wait_pid[s]; rd_wait[s] = 0;
               end
            end else begin
               wr_wait[s] = 1; wr_wait_pid[s] = r.requester_pid; o.status = ST_WAIT;
            end
         end
         CMD_READ: begin
            s = find_slot(r.descriptor);
            if (s < 0 || read_number[s] != r.descriptor) o.status = ST_BADFD;
            else if (fill_count[s] > 0) begin
               o.read_byte = pipe_bytes[s*PipeDepth + head_idx[s]];
               head_idx[s] = (head_idx[s] + 1) % PipeDepth;
               fill_count[s]--;
               if (wr_wait[s]) begin
                  o.wake_valid = 1; o.wake_pid = wr_wait_pid[s]; wr_wait[s] = 0;
               end
            end else if (!wr_open[s]) o.status = ST_EOF;
            else begin
               rd_wait[s] = 1; rd_wait_pid[s] = r.requester_pid; o.status = ST_WAIT;
            end
         end
         CMD_CLOSE: begin
            s = find_slot(r.descriptor);
            if (s < 0) o.status = ST_BADFD;
            else begin
               if (read_number[s] == r.descriptor) begin
                  rd_open[s] = 0;
                  if (wr_wait[s]) begin
                     o.wake_valid = 1; o.wake_pid = wr_wait_pid[s]; wr_wait[s] = 0;
                  end
               end else begin
                  wr_open[s] = 0;
                  if (rd_wait[s]) begin
                     o.wake_valid = 1; o.wake_pid = rd_wait_pid[s]; rd_wait[s] = 0;
                  end
               end
               if (!rd_open[s] && !wr_open[s]) pipe_active[s] = 0;
            end
         end
         CMD_QUERY:
            o.is_pipe = (r.descriptor >= base_number && find_slot(r.descriptor) >= 0);
         default: o.status = ST_BADFD;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   // Driver: presents queued commands, predicting each on its transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_responses.push_back(predict_response(req_data));
            void'(pending_requests.pop_front());
         end
         if (!(req_valid && !req_ready)) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_requests[0];
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each response transfer and drives the ready side.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_data.status != want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.read_byte != want.read_byte)
                  report_mismatch("read_byte", rsp_data.read_byte, want.read_byte);
               if (rsp_data.new_read_descriptor != want.new_read_descriptor)
                  report_mismatch("new_read_descriptor", rsp_data.new_read_descriptor,
                                  want.new_read_descriptor);
               if (rsp_data.new_write_descriptor != want.new_write_descriptor)
                  report_mismatch("new_write_descriptor", rsp_data.new_write_descriptor,
                                  want.new_write_descriptor);
               if (rsp_data.wake_valid != want.wake_valid)
                  report_mismatch("wake_valid", rsp_data.wake_valid, want.wake_valid);
               if (rsp_data.wake_pid != want.wake_pid)
                  report_mismatch("wake_pid", rsp_data.wake_pid, want.wake_pid);
               if (rsp_data.is_pipe != want.is_pipe)
                  report_mismatch("is_pipe", rsp_data.is_pipe, want.is_pipe);
               if (rsp_data.last_of_call != want.last_of_call)
                  report_mismatch("last_of_call", rsp_data.last_of_call, want.last_of_call);
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Descriptors handed out so far, used to aim commands at real pipes.
   logic [15:0] known_numbers[$];

   function automatic req_type make_req(cmd_type c, logic [15:0] d);
      req_type r;
      r.cmd = c;
      r.descriptor = d;
      r.write_byte = 8'($urandom_range(255));
      r.requester_pid = 8'($urandom_range(255));
      r.last_byte = 1'($urandom_range(1));
      return r;
   endfunction

   // Picks a descriptor: mostly a known one, sometimes random.
   function automatic logic [15:0] pick_descriptor();
      logic [15:0] d;
      if (known_numbers.size() > 0 && $urandom_range(9) < 9)
         d = known_numbers[$urandom_range(known_numbers.size() - 1)];
      else
         d = 16'($urandom_range(16'hFFFF));
      return d;
   endfunction

   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_valid || expected_responses.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_base(logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      base_number = value;
      counter_number = value;
      known_numbers.delete();
   endtask

   // Queues a random burst that favors moving bytes.
   task automatic queue_random(int count);
      int pick;
      req_type r;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 8) r = make_req(CMD_CREATE, 16'($urandom_range(16'hFFFF)));
         else if (pick < 45) r = make_req(CMD_WRITE, pick_descriptor() | 16'h0);
         else if (pick < 78) r = make_req(CMD_READ, pick_descriptor());
         else if (pick < 86) r = make_req(CMD_CLOSE, pick_descriptor());
         else if (pick < 96) r = make_req(CMD_QUERY, pick_descriptor());
         else r = make_req(cmd_type'($urandom_range(5, 7)), pick_descriptor());
         // Writes land on the write end and reads on the read end most of the time.
         if (r.cmd == CMD_WRITE && $urandom_range(3) != 0) r.descriptor[0] = ~base_number[0];
         if (r.cmd == CMD_READ && $urandom_range(3) != 0) r.descriptor[0] = base_number[0];
         pending_requests.push_back(r);
         if (r.cmd == CMD_CREATE) begin
            known_numbers.push_back(counter_number + 16'(known_numbers.size()));
            known_numbers.push_back(counter_number + 16'(known_numbers.size()));
         end
      end
   endtask

   initial begin
      req_type r;
      clear_pool();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part: one pipe through every path, then the full pool.
      pending_requests.push_back(make_req(CMD_READ, 16'd3));
      pending_requests.push_back(make_req(CMD_CREATE, 16'd0));
      pending_requests.push_back(make_req(CMD_QUERY, 16'd3));
      pending_requests.push_back(make_req(CMD_QUERY, 16'd2));
      pending_requests.push_back(make_req(CMD_READ, 16'd4));
      pending_requests.push_back(make_req(CMD_READ, 16'd3));
      r = make_req(CMD_WRITE, 16'd4); r.write_byte = 8'hFF; r.last_byte = 1;
      pending_requests.push_back(r);
      r = make_req(CMD_WRITE, 16'd4); r.write_byte = 8'h00; r.requester_pid = 8'hFF;
      pending_requests.push_back(r);
      pending_requests.push_back(make_req(CMD_WRITE, 16'd3));
      pending_requests.push_back(make_req(CMD_READ, 16'd3));
      pending_requests.push_back(make_req(CMD_CLOSE, 16'd4));
      pending_requests.push_back(make_req(CMD_READ, 16'd3));
      pending_requests.push_back(make_req(CMD_READ, 16'd3));
      pending_requests.push_back(make_req(CMD_CLOSE, 16'd3));
      pending_requests.push_back(make_req(CMD_CLOSE, 16'hFFFF));
      pending_requests.push_back(make_req(cmd_type'(3'd7), 16'd3));
      pending_requests.push_back(make_req(cmd_type'(3'd5), 16'd3));
      for (int i = 0; i <= PipeCount; i++)
         pending_requests.push_back(make_req(CMD_CREATE, 16'd0));
      // Close every end of the full pool so the next phase starts empty.
      for (int d = 5; d <= 4 + 2 * PipeCount; d++)
         pending_requests.push_back(make_req(CMD_CLOSE, 16'(d)));
      wait_drained();

      // Fill one pipe, with a reader waiting first and a blocked writer at the end.
      write_base(16'hFFFC);
      base_number = 16'hFFFC; counter_number = 16'hFFFC;
      pending_requests.push_back(make_req(CMD_CREATE, 16'd0));
      pending_requests.push_back(make_req(CMD_CREATE, 16'd0));
      pending_requests.push_back(make_req(CMD_CREATE, 16'd0));
      pending_requests.push_back(make_req(CMD_READ, 16'hFFFC));
      for (int i = 0; i <= PipeDepth; i++) pending_requests.push_back(make_req(CMD_WRITE, 16'hFFFD));
      pending_requests.push_back(make_req(CMD_QUERY, 16'h0000));
      pending_requests.push_back(make_req(CMD_READ, 16'hFFFC));
      pending_requests.push_back(make_req(CMD_CLOSE, 16'hFFFC));
      pending_requests.push_back(make_req(CMD_WRITE, 16'hFFFD));
      pending_requests.push_back(make_req(CMD_CLOSE, 16'hFFFD));
      pending_requests.push_back(make_req(CMD_CLOSE, 16'h0000));
      pending_requests.push_back(make_req(CMD_CLOSE, 16'h0001));
      pending_requests.push_back(make_req(CMD_CLOSE, 16'hFFFE));
      pending_requests.push_back(make_req(CMD_CLOSE, 16'hFFFF));
      // The receiver holds off while the sender keeps offering.
      hold_cycles = 300;
      wait_drained();

      // Random phases under three settings and three idling mixes.
      write_base(16'h0000);
      queue_random(275);
      wait_drained();
      send_idle_pct = 61; recv_idle_pct = 23;
      write_base(16'h8001);
      queue_random(275);
      wait_drained();
      send_idle_pct = 0; recv_idle_pct = 0;
      write_base(16'hFFF0);
      queue_random(275);
      wait_drained();

      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
